// ===== hdl/sitoa_pkg.sv =====
package sitoa_pkg;

  localparam int VALUE_WIDTH = 32;

  localparam int DigitBase = 10;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  function automatic int max_digits_f();
    logic [VALUE_WIDTH:0] m;
    int n;
    m = {{VALUE_WIDTH{1'b0}}, 1'b1} << (VALUE_WIDTH - 1);
    n = 0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (m != '0) begin
        n = n + 1;
        m = m / DigitBase;
      end
    end
    return n;
  endfunction

  localparam int MaxDigits = max_digits_f();
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int IdxW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  // reciprocal of ten, ceil(2^(W+3) / 10), exact for every W-bit magnitude
  localparam int RecipShift = VALUE_WIDTH + 3;
  localparam logic [VALUE_WIDTH+3:0] RecipNum =
    ({{(VALUE_WIDTH+3){1'b0}}, 1'b1} << RecipShift) + (VALUE_WIDTH+4)'(DigitBase - 1);
  localparam logic [VALUE_WIDTH+3:0] RecipWide = RecipNum / DigitBase;
  localparam logic [VALUE_WIDTH-1:0] Recip = RecipWide[VALUE_WIDTH-1:0];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } sitoa_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push_sign;
    logic push_digit;
  } sitoa_cmd_t;

  typedef struct packed {
    logic neg;
    logic div_done;
    logic slot_free;
    logic last_digit;
  } sitoa_sts_t;

endpackage

// ===== hdl/sitoa_ctrl.sv =====
module sitoa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sitoa_pkg::sitoa_sts_t sts,
  output sitoa_pkg::sitoa_cmd_t cmd
);
  import sitoa_pkg::*;

  sitoa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free && sts.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV:  cmd.step = 1'b1;
      ST_SIGN: cmd.push_sign = sts.slot_free;
      ST_EMIT: cmd.push_digit = sts.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/sitoa_dp.sv =====
module sitoa_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] in_value,
  input  sitoa_pkg::sitoa_cmd_t                cmd,
  output sitoa_pkg::sitoa_sts_t                sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_text_char,
  output logic                                 out_last_char
);
  import sitoa_pkg::*;

  logic [VALUE_WIDTH-1:0]   mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic [3:0]               digits_r [MaxDigits];
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               char_r, char_nxt;
  logic                     last_r, last_nxt;

  logic [2*VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0]   quot;
  logic [VALUE_WIDTH-1:0]   quot10;
  logic [VALUE_WIDTH-1:0]   rem_full;
  logic [3:0]               rem;
  logic [CntW-1:0]          cnt_dec;
  logic [3:0]               rd_digit;
  logic                     push;

  // divide by ten through the reciprocal
  assign prod     = {{VALUE_WIDTH{1'b0}}, mag_r} * {{VALUE_WIDTH{1'b0}}, Recip};
  assign quot     = VALUE_WIDTH'(prod[2*VALUE_WIDTH-1:RecipShift]);
  assign quot10   = (quot << 3) + (quot << 1);
  assign rem_full = mag_r - quot10;
  assign rem      = rem_full[3:0];

  assign cnt_dec  = cnt_r - CntW'(1);
  assign rd_digit = digits_r[cnt_dec[IdxW-1:0]];
  assign push     = cmd.push_sign | cmd.push_digit;

  assign sts.neg        = neg_r;
  assign sts.div_done   = (quot == '0) || (cnt_r == CntW'(MaxDigits - 1));
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.last_digit = (cnt_r == CntW'(1));

  always_comb begin
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      neg_nxt = in_value[VALUE_WIDTH-1];
      mag_nxt = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      cnt_nxt = '0;
    end else if (cmd.step) begin
      mag_nxt = quot;
      cnt_nxt = cnt_r + CntW'(1);
    end else if (cmd.push_digit) begin
      cnt_nxt = cnt_dec;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      char_nxt      = cmd.push_sign ? CharMinus : (CharZero + {4'b0000, rd_digit});
      last_nxt      = cmd.push_digit && (cnt_r == CntW'(1));
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (cmd.step) begin
      digits_r[cnt_r[IdxW-1:0]] <= rem;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// signed integer to decimal ascii text
//
// input channel: in_valid / in_ready / in_value, one signed word per number.
// output channel: out_valid / out_ready / out_text_char / out_last_char, one
// character per word: '-' for negative values, then the digits most
// significant first; out_last_char marks the final digit. zero gives '0'.
//
// sequence: after a word is taken, the divide-by-ten unit runs once per decimal
// digit (d digits, up to 10 at 32 bits), then the sign and digits leave one
// per cycle while the receiver takes them; a stall holds them. the single
// divide-by-ten step is a reciprocal multiply and there is a single output
// register; in_ready is high only between numbers.
// the output register parts the sides: the next number is taken while the
// last character of the previous one still waits. a stalled receiver holds
// the character and its flag steady and the block waits for it.
// reset (synchronous, active low) returns the controller to idle, empties the
// output register and clears the digit count and sign; no other state is reset.
module signed_int_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_text_char,
  output logic                                 out_last_char
);
  import sitoa_pkg::*;

  sitoa_cmd_t cmd;
  sitoa_sts_t sts;

  sitoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitoa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

// ===== hdl/sitoa_checker.sv =====
module sitoa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_text_char,
  input logic       out_last_char
);
  import sitoa_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char) && $stable(out_last_char))
    else $error("output word changed while stalled");

  // only a minus sign or a digit leaves the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == CharMinus) ||
                  (out_text_char >= CharZero && out_text_char <= CharZero + 8'd9))
    else $error("output character out of set");

  // the sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_char == CharMinus |-> !out_last_char)
    else $error("minus sign marked last");

  // a sign is followed by a digit
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_text_char == CharMinus ##1 out_valid |->
      out_text_char != CharMinus)
    else $error("two minus signs in a row");

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_text_char (out_text_char),
  .out_last_char (out_last_char)
);
